// ===== hdl/eihp_pkg.sv =====
// ----------------------------------------------------------------------------
// eihp_pkg
// Types and constants shared by the header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none
package eihp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  packet_kind;
    logic [15:0] ether_type;
    logic [7:0]  proto_number;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [31:0] ack_or_length;
    logic [7:0]  tcp_flag_bits;
    logic [11:0] payload_offset;
    logic [11:0] payload_length;
  } out_item_t;

  localparam logic [3:0] KIND_UNKNOWN = 4'd0;
  localparam logic [3:0] KIND_ETH     = 4'd1;
  localparam logic [3:0] KIND_ARP     = 4'd2;
  localparam logic [3:0] KIND_IP4     = 4'd3;
  localparam logic [3:0] KIND_IP4_TCP = 4'd4;
  localparam logic [3:0] KIND_IP4_UDP = 4'd5;
  localparam logic [3:0] KIND_IP4_ICMP = 4'd6;
  localparam logic [3:0] KIND_IP4_FRAG = 4'd7;
  localparam logic [3:0] KIND_IP6     = 4'd8;
  localparam logic [3:0] KIND_IP6_TCP = 4'd9;
  localparam logic [3:0] KIND_IP6_UDP = 4'd10;
  localparam logic [3:0] KIND_DISCARD = 4'd11;

  localparam logic [15:0] ETYPE_IP4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IP6 = 16'h86DD;

  localparam logic [7:0] NH_HOP  = 8'd0;
  localparam logic [7:0] NH_ICMP = 8'd1;
  localparam logic [7:0] NH_TCP  = 8'd6;
  localparam logic [7:0] NH_UDP  = 8'd17;
  localparam logic [7:0] NH_ROUTE = 8'd43;
  localparam logic [7:0] NH_FRAG = 8'd44;
  localparam logic [7:0] NH_ESP  = 8'd50;
  localparam logic [7:0] NH_AH   = 8'd51;
  localparam logic [7:0] NH_DEST = 8'd60;

  // Frame summary handed from the parser to the result formatter.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  nh;
    logic [63:0] f0;
    logic [63:0] f1;
    logic [63:0] f2;
    logic [15:0] start;
    logic [15:0] limit;
    logic [15:0] length;
  } summary_t;

endpackage
`default_nettype wire

// ===== hdl/ethernet_ip_l4_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser_top
// Ethernet / ARP / IPv4 / IPv6 / TCP / UDP / ICMP header parser.
// ----------------------------------------------------------------------------
// Feed a captured frame one byte per item; the item with last_byte set
// closes the frame and yields one result item. Bytes are taken one per clock
// unless the queue is full, with no gaps between frames: the front parser
// walks the headers on the fly, a two-entry summary queue decouples it from
// the back formatter, whose output register holds the result while the
// receiver stalls. The last byte's summary passes through the queue into the
// output register. Bytes past MAX_FRAME are ignored but still end a frame.
// ----------------------------------------------------------------------------
`default_nettype none
module ethernet_ip_l4_header_parser_top #(
  parameter int MAX_FRAME = 2048
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  eihp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output eihp_pkg::out_item_t  out_item
);
  import eihp_pkg::*;

  summary_t summary, q_data;
  logic     q_full, q_valid, q_pop, accept, push;

  // Hold input off while the queue cannot take a summary.
  assign in_stall = q_full;
  assign accept   = !q_full;
  assign push     = in_valid && accept && in_item.last_byte;

  eihp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk, .rst, .in_valid, .in_item, .accept, .summary
  );

  eihp_queue u_queue (
    .clk, .rst, .push, .push_data(summary), .full(q_full),
    .not_empty(q_valid), .pop(q_pop), .pop_data(q_data)
  );

  eihp_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .out_valid, .out_item, .out_stall
  );

`ifndef SYNTHESIS
  // A result must come from a queued summary.
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  // Output register must not be overwritten while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !q_pop) else $error("stalled result lost");
  // No push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("queue overflow");
`endif

endmodule
`default_nettype wire

// ===== hdl/eihp_front.sv =====
// ----------------------------------------------------------------------------
// eihp_front
// Byte-at-a-time header walker; emits a frame summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none
module eihp_front #(
  parameter int MAX_FRAME = 2048
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  eihp_pkg::in_item_t   in_item,
  input  wire                  accept,
  output eihp_pkg::summary_t   summary
);
  import eihp_pkg::*;

  localparam int PW = $clog2(MAX_FRAME + 1);

  typedef enum logic [3:0] {
    ST_ETH, ST_IP4, ST_ARP, ST_IP6, ST_EXT, ST_AH, ST_FRAG,
    ST_TCP, ST_UDP, ST_ICMP, ST_ESP, ST_DONE
  } stage_t;

  logic [PW-1:0] pos;
  stage_t        stage;
  logic [11:0]   idx;
  logic [11:0]   slen;
  logic [7:0]    nh;
  logic [15:0]   limit;
  logic [15:0]   frag;
  logic [63:0]   f0, f1, f2;
  logic [15:0]   start;
  logic [3:0]    kind;

  logic [PW-1:0] pos_next;
  stage_t        stage_next;
  logic [11:0]   idx_next;
  logic [11:0]   slen_next;
  logic [7:0]    nh_next;
  logic [15:0]   limit_next;
  logic [15:0]   frag_next;
  logic [63:0]   f0_next, f1_next, f2_next;
  logic [15:0]   start_next;
  logic [3:0]    kind_next;

  logic [15:0] pos16, np;
  logic [16:0] lim_sum;
  logic [7:0]  b;
  logic        in_range;
  logic        stop;

  assign b = in_item.data_byte;
  assign in_range = (PW'(pos) < PW'(MAX_FRAME)) && (pos != PW'(MAX_FRAME));
  assign pos16 = 16'(pos);
  assign np = pos16 + 16'd1;

  always_comb begin
    pos_next = pos; stage_next = stage; idx_next = idx; slen_next = slen;
    nh_next = nh; limit_next = limit; frag_next = frag;
    f0_next = f0; f1_next = f1; f2_next = f2; start_next = start;
    kind_next = kind; stop = 1'b0; lim_sum = 17'd0;
    if (in_range) begin
      pos_next = pos + PW'(1);
      if (stage != ST_DONE) begin
        if (pos16 >= limit) begin
          stage_next = ST_DONE; stop = 1'b1;
        end else begin
          case (stage)
            ST_ETH: begin
              if (idx == 12'd12) f2_next[31:24] = b;
              if (idx == 12'd13) f2_next[23:16] = b;
            end
            ST_IP4: begin
              if (idx == 12'd0) begin
                if (b[3:0] < 4'd5) begin
                  stage_next = ST_DONE; stop = 1'b1;
                end else slen_next = {6'd0, b[3:0], 2'b00};
              end
              if (idx == 12'd6) frag_next[15:8] = b;
              if (idx == 12'd7) frag_next[7:0] = b;
              if (idx == 12'd9) nh_next = b;
              if (idx >= 12'd12 && idx <= 12'd19)
                f0_next[8*(7-(idx[2:0]^3'd4)) +: 8] = b;
            end
            ST_ARP: begin
              if (idx == 12'd6) f1_next[15:8] = b;
              if (idx == 12'd7) f1_next[7:0] = b;
              if (idx >= 12'd14 && idx <= 12'd17)
                f0_next[8*(7-(idx[1:0]^2'd2)) +: 8] = b;
              if (idx >= 12'd24 && idx <= 12'd27)
                f0_next[8*(3-idx[1:0]) +: 8] = b;
            end
            ST_IP6: begin
              if (idx == 12'd0 && b[7:4] != 4'd6) begin
                stage_next = ST_DONE; stop = 1'b1;
              end
              if (idx == 12'd4) frag_next[15:8] = b;
              if (idx == 12'd5) frag_next[7:0] = b;
              if (idx == 12'd6) nh_next = b;
            end
            ST_EXT: begin
              if (idx == 12'd0) nh_next = b;
              if (idx == 12'd1) slen_next = {({1'b0, b} + 9'd1), 3'b000};
            end
            ST_AH: begin
              if (idx == 12'd0) nh_next = b;
              if (idx == 12'd1) slen_next = {1'b0, 9'(b) + 9'd2, 2'b00};
            end
            ST_FRAG: begin
              if (idx == 12'd0) nh_next = b;
              if (idx == 12'd2) frag_next[15:8] = b;
              if (idx == 12'd3) frag_next[7:0] = b;
            end
            ST_TCP: begin
              if (idx <= 12'd3) f2_next[8*(7-idx[1:0]) +: 8] = b;
              else if (idx <= 12'd11) f1_next[8*(7-3'(idx-12'd4)) +: 8] = b;
              else if (idx == 12'd12) begin
                if (b[7:4] < 4'd5) begin
                  stage_next = ST_DONE; stop = 1'b1;
                end else slen_next = {6'd0, b[7:4], 2'b00};
              end else if (idx == 12'd13) f2_next[7:0] = b;
            end
            ST_UDP: begin
              if (idx <= 12'd3) f2_next[8*(7-idx[1:0]) +: 8] = b;
              else if (idx == 12'd4) f1_next[15:8] = b;
              else if (idx == 12'd5) f1_next[7:0] = b;
            end
            ST_ICMP: begin
              if (idx == 12'd0) f2_next[55:48] = b;
              if (idx == 12'd1) f2_next[39:32] = b;
            end
            default: ;
          endcase
          if (!stop) begin
            if (idx + 12'd1 >= slen_next) begin
              idx_next = 12'd0;
              case (stage)
                ST_ETH: begin
                  kind_next = KIND_ETH;
                  if (f2_next[31:16] == ETYPE_IP4) begin
                    stage_next = ST_IP4; slen_next = 12'd20;
                  end else if (f2_next[31:16] == ETYPE_ARP) begin
                    stage_next = ST_ARP; slen_next = 12'd28;
                  end else if (f2_next[31:16] == ETYPE_IP6) begin
                    kind_next = KIND_DISCARD; stage_next = ST_IP6; slen_next = 12'd40;
                  end else stage_next = ST_DONE;
                end
                ST_IP4: begin
                  start_next = np;
                  if (frag_next[13:0] != 14'd0) begin
                    kind_next = KIND_IP4_FRAG; stage_next = ST_DONE;
                  end else begin
                    kind_next = KIND_IP4;
                    if (nh_next == NH_TCP) begin
                      stage_next = ST_TCP; slen_next = 12'd20;
                    end else if (nh_next == NH_UDP) begin
                      stage_next = ST_UDP; slen_next = 12'd8;
                    end else if (nh_next == NH_ICMP) begin
                      stage_next = ST_ICMP; slen_next = 12'd8;
                    end else stage_next = ST_DONE;
                  end
                end
                ST_ARP: begin
                  kind_next = KIND_ARP; stage_next = ST_DONE;
                end
                ST_ESP: begin
                  kind_next = KIND_IP6; stage_next = ST_DONE;
                end
                ST_TCP: begin
                  kind_next = (kind == KIND_IP4) ? KIND_IP4_TCP : KIND_IP6_TCP;
                  start_next = np; stage_next = ST_DONE;
                end
                ST_UDP: begin
                  kind_next = (kind == KIND_IP4) ? KIND_IP4_UDP : KIND_IP6_UDP;
                  start_next = np; stage_next = ST_DONE;
                end
                ST_ICMP: begin
                  kind_next = KIND_IP4_ICMP; stage_next = ST_DONE;
                end
                ST_IP6, ST_EXT, ST_AH, ST_FRAG: begin
                  kind_next = KIND_IP6; start_next = np;
                  if (stage == ST_IP6) begin
                    // payload end = first byte after the header plus payload length
                    lim_sum = {1'b0, np} + {1'b0, frag_next};
                    limit_next = lim_sum[16] ? 16'hFFFF : lim_sum[15:0];
                    frag_next = 16'd0;
                  end
                  if (stage == ST_FRAG &&
                      (frag_next[15:3] != 13'd0 || frag_next[0])) begin
                    stage_next = ST_DONE;
                  end else begin
                    // next-header dispatch
                    case (nh_next)
                      NH_HOP, NH_ROUTE, NH_DEST: begin
                        kind_next = KIND_DISCARD; stage_next = ST_EXT; slen_next = 12'd8;
                      end
                      NH_AH: begin
                        kind_next = KIND_DISCARD; stage_next = ST_AH; slen_next = 12'd8;
                      end
                      NH_FRAG: begin
                        kind_next = KIND_DISCARD; stage_next = ST_FRAG; slen_next = 12'd8;
                      end
                      NH_ESP: begin
                        kind_next = KIND_DISCARD; stage_next = ST_ESP; slen_next = 12'd2;
                      end
                      NH_TCP: begin
                        stage_next = ST_TCP; slen_next = 12'd20;
                      end
                      NH_UDP: begin
                        stage_next = ST_UDP; slen_next = 12'd8;
                      end
                      default: stage_next = ST_DONE;
                    endcase
                  end
                end
                default: stage_next = ST_DONE;
              endcase
            end else idx_next = idx + 12'd1;
          end
        end
      end
    end
  end

  always_comb begin
    summary.kind   = kind_next;
    summary.nh     = nh_next;
    summary.f0     = f0_next;
    summary.f1     = f1_next;
    summary.f2     = f2_next;
    summary.start  = start_next;
    summary.limit  = limit_next;
    summary.length = 16'(pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_valid && in_item.last_byte)) begin
      pos <= '0; stage <= ST_ETH; idx <= '0; slen <= 12'd14; nh <= '0;
      limit <= 16'hFFFF; frag <= '0; f0 <= '0; f1 <= '0; f2 <= '0;
      start <= '0; kind <= KIND_UNKNOWN;
    end else if (accept && in_valid) begin
      pos <= pos_next; stage <= stage_next; idx <= idx_next; slen <= slen_next;
      nh <= nh_next; limit <= limit_next; frag <= frag_next;
      f0 <= f0_next; f1 <= f1_next; f2 <= f2_next;
      start <= start_next; kind <= kind_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/eihp_queue.sv =====
// ----------------------------------------------------------------------------
// eihp_queue
// Two-entry summary queue between the parser and the result formatter.
// ----------------------------------------------------------------------------
`default_nettype none
module eihp_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  eihp_pkg::summary_t  push_data,
  output logic                full,
  output logic                not_empty,
  input  wire                 pop,
  output eihp_pkg::summary_t  pop_data
);
  import eihp_pkg::*;

  summary_t    mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/eihp_back.sv =====
// ----------------------------------------------------------------------------
// eihp_back
// Turns a frame summary into a result item held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module eihp_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  eihp_pkg::summary_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  output eihp_pkg::out_item_t out_item,
  input  wire                 out_stall
);
  import eihp_pkg::*;

  out_item_t r;
  logic [3:0] k;
  logic [15:0] end_pos, diff;

  assign q_pop = q_valid && (!out_valid || !out_stall);
  assign k = q_data.kind;
  assign end_pos = (q_data.length < q_data.limit) ? q_data.length : q_data.limit;
  assign diff = end_pos - q_data.start;

  always_comb begin
    r = '0;
    r.packet_kind = k;
    if (k != KIND_UNKNOWN && k != KIND_DISCARD) begin
      r.ether_type = q_data.f2[31:16];
      if (k == KIND_ARP) begin
        r.src_addr = q_data.f0[63:32];
        r.dst_addr = q_data.f0[31:0];
        r.ack_or_length = q_data.f1[31:0];
      end else if (k >= KIND_IP4) begin
        r.proto_number = q_data.nh;
        if (k <= KIND_IP4_FRAG) begin
          r.src_addr = q_data.f0[63:32];
          r.dst_addr = q_data.f0[31:0];
        end
        if (k inside {KIND_IP4_TCP, KIND_IP4_UDP, KIND_IP4_ICMP,
                      KIND_IP6_TCP, KIND_IP6_UDP}) begin
          r.src_port = q_data.f2[63:48];
          r.dst_port = q_data.f2[47:32];
        end
        if (k inside {KIND_IP4_TCP, KIND_IP6_TCP}) begin
          r.seq_number = q_data.f1[63:32];
          r.tcp_flag_bits = q_data.f2[7:0];
        end
        if (k inside {KIND_IP4_TCP, KIND_IP4_UDP, KIND_IP6_TCP, KIND_IP6_UDP})
          r.ack_or_length = q_data.f1[31:0];
        r.payload_offset = q_data.start[11:0];
        r.payload_length = (end_pos > q_data.start) ? diff[11:0] : 12'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_item <= r;
  end

endmodule
`default_nettype wire

// ===== bench/tb_ethernet_ip_l4_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_ethernet_ip_l4_header_parser_top
// Frame-level test of the Ethernet / IP / L4 header parser.
// ----------------------------------------------------------------------------
// Builds Ethernet, ARP, IPv4 and IPv6 frames (with extension chains, TCP,
// UDP and ICMP, cut short or malformed), streams them byte by byte, predicts
// each frame summary from a parser model of its own and checks every result
// item against the oldest prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_ethernet_ip_l4_header_parser_top;
  import eihp_pkg::*;

  localparam int FRAME_CAP = 2048;

  typedef enum logic [3:0] {
    HS_ETH, HS_IP4, HS_ARP, HS_IP6, HS_EXT, HS_AH, HS_FRAG,
    HS_TCP, HS_UDP, HS_ICMP, HS_ESP, HS_DONE
  } hdr_stage_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;

  ethernet_ip_l4_header_parser_top #(.MAX_FRAME(FRAME_CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // Parser model state, cleared at the end of every frame.
  int unsigned  pm_pos;
  hdr_stage_t   pm_stage;
  int unsigned  pm_idx;
  int unsigned  pm_len;
  logic [7:0]   pm_nh;
  int unsigned  pm_limit;
  logic [15:0]  pm_frag;
  logic [63:0]  pm_cf [4];
  logic [3:0]   pm_kind;

  out_item_t    summary_q[$];
  logic [7:0]   frame_q[$];
  logic [7:0]   chain_q[$];

  int  errors;
  int  frames_sent;
  int  bytes_sent;
  int  results_seen;
  int  kind_hits [16];
  bit  idle_on;
  int  hold_count;

  // Clock; the single reset at the start is driven by the main initial block.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up after a generous fixed time.
  initial begin
    #4000000;
    $display("tb_ethernet_ip_l4_header_parser_top: errors");
    $finish;
  end

  // ---------------- parser model ----------------
  task automatic frame_clear();
    pm_pos = 0; pm_stage = HS_ETH; pm_idx = 0; pm_len = 14; pm_nh = 8'd0;
    pm_limit = 32'hFFFF; pm_frag = 16'd0; pm_kind = KIND_UNKNOWN;
    for (int w = 0; w < 4; w++) pm_cf[w] = 64'd0;
  endtask

  task automatic put_byte(int w, int bitpos, logic [7:0] b);
    pm_cf[w][bitpos +: 8] = b;
  endtask

  task automatic enter_stage(hdr_stage_t st, int unsigned len);
    pm_stage = st; pm_idx = 0; pm_len = len;
  endtask

  task automatic v6_next();
    case (pm_nh)
      NH_HOP, NH_ROUTE, NH_DEST: begin
        pm_kind = KIND_DISCARD; enter_stage(HS_EXT, 8);
      end
      NH_AH: begin
        pm_kind = KIND_DISCARD; enter_stage(HS_AH, 8);
      end
      NH_FRAG: begin
        pm_kind = KIND_DISCARD; enter_stage(HS_FRAG, 8);
      end
      NH_ESP: begin
        pm_kind = KIND_DISCARD; enter_stage(HS_ESP, 2);
      end
      NH_TCP: enter_stage(HS_TCP, 20);
      NH_UDP: enter_stage(HS_UDP, 8);
      default: pm_stage = HS_DONE;
    endcase
  endtask

  task automatic close_header(int unsigned np);
    int unsigned lim;
    logic [15:0] et;
    case (pm_stage)
      HS_ETH: begin
        et = pm_cf[2][31:16];
        pm_kind = KIND_ETH;
        if (et == ETYPE_IP4) enter_stage(HS_IP4, 20);
        else if (et == ETYPE_ARP) enter_stage(HS_ARP, 28);
        else if (et == ETYPE_IP6) begin
          pm_kind = KIND_DISCARD; enter_stage(HS_IP6, 40);
        end else pm_stage = HS_DONE;
      end
      HS_IP4: begin
        pm_cf[3] = 64'(np);
        if (pm_frag[12:0] != 0 || pm_frag[13]) begin
          pm_kind = KIND_IP4_FRAG; pm_stage = HS_DONE;
        end else begin
          pm_kind = KIND_IP4;
          if (pm_nh == NH_TCP) enter_stage(HS_TCP, 20);
          else if (pm_nh == NH_UDP) enter_stage(HS_UDP, 8);
          else if (pm_nh == NH_ICMP) enter_stage(HS_ICMP, 8);
          else pm_stage = HS_DONE;
        end
      end
      HS_ARP: begin
        pm_kind = KIND_ARP; pm_stage = HS_DONE;
      end
      HS_IP6: begin
        pm_kind = KIND_IP6; pm_cf[3] = 64'(np);
        lim = np + 32'(pm_frag);
        pm_limit = (lim > 32'hFFFF) ? 32'hFFFF : lim;
        pm_frag = 16'd0;
        v6_next();
      end
      HS_EXT, HS_AH: begin
        pm_kind = KIND_IP6; pm_cf[3] = 64'(np); v6_next();
      end
      HS_FRAG: begin
        pm_kind = KIND_IP6; pm_cf[3] = 64'(np);
        if (pm_frag[15:3] != 0 || pm_frag[0]) pm_stage = HS_DONE;
        else v6_next();
      end
      HS_ESP: begin
        pm_kind = KIND_IP6; pm_stage = HS_DONE;
      end
      HS_TCP: begin
        pm_kind = (pm_kind == KIND_IP4) ? KIND_IP4_TCP : KIND_IP6_TCP;
        pm_cf[3] = 64'(np); pm_stage = HS_DONE;
      end
      HS_UDP: begin
        pm_kind = (pm_kind == KIND_IP4) ? KIND_IP4_UDP : KIND_IP6_UDP;
        pm_cf[3] = 64'(np); pm_stage = HS_DONE;
      end
      HS_ICMP: begin
        pm_kind = KIND_IP4_ICMP; pm_stage = HS_DONE;
      end
      default: pm_stage = HS_DONE;
    endcase
  endtask

  task automatic parse_byte(logic [7:0] b, int unsigned p);
    int unsigned i;
    i = pm_idx;
    if (pm_stage == HS_DONE) return;
    if (p >= pm_limit) begin
      pm_stage = HS_DONE;
      return;
    end
    case (pm_stage)
      HS_ETH: if (i == 12 || i == 13) put_byte(2, (i == 12) ? 24 : 16, b);
      HS_IP4: begin
        if (i == 0) begin
          if (b[3:0] < 5) begin
            pm_stage = HS_DONE;
            return;
          end
          pm_len = 32'(b[3:0]) * 4;
        end else if (i == 6) pm_frag[15:8] = b;
        else if (i == 7) pm_frag[7:0] = b;
        else if (i == 9) pm_nh = b;
        else if (i >= 12 && i <= 19) put_byte(0, 56 - (i - 12) * 8, b);
      end
      HS_ARP: begin
        if (i == 6 || i == 7) put_byte(1, (i == 6) ? 8 : 0, b);
        else if (i >= 14 && i <= 17) put_byte(0, 56 - (i - 14) * 8, b);
        else if (i >= 24 && i <= 27) put_byte(0, 24 - (i - 24) * 8, b);
      end
      HS_IP6: begin
        if (i == 0 && b[7:4] != 4'd6) begin
          pm_stage = HS_DONE;
          return;
        end
        if (i == 4) pm_frag[15:8] = b;
        else if (i == 5) pm_frag[7:0] = b;
        else if (i == 6) pm_nh = b;
      end
      HS_EXT: begin
        if (i == 0) pm_nh = b;
        else if (i == 1) pm_len = (32'(b) + 1) * 8;
      end
      HS_AH: begin
        if (i == 0) pm_nh = b;
        else if (i == 1) pm_len = (32'(b) + 2) * 4;
      end
      HS_FRAG: begin
        if (i == 0) pm_nh = b;
        else if (i == 2) pm_frag[15:8] = b;
        else if (i == 3) pm_frag[7:0] = b;
      end
      HS_TCP: begin
        if (i <= 3) put_byte(2, 56 - i * 8, b);
        else if (i <= 11) put_byte(1, 56 - (i - 4) * 8, b);
        else if (i == 12) begin
          if (32'(b[7:4]) * 4 < 20) begin
            pm_stage = HS_DONE;
            return;
          end
          pm_len = 32'(b[7:4]) * 4;
        end else if (i == 13) put_byte(2, 0, b);
      end
      HS_UDP: begin
        if (i <= 3) put_byte(2, 56 - i * 8, b);
        else if (i == 4 || i == 5) put_byte(1, (i == 4) ? 8 : 0, b);
      end
      HS_ICMP: begin
        if (i == 0) put_byte(2, 48, b);
        else if (i == 1) put_byte(2, 32, b);
      end
      default: ;
    endcase
    if (i + 1 >= pm_len) close_header(p + 1);
    else pm_idx = i + 1;
  endtask

  // Advance the model by one accepted byte; queue the summary on the last one.
  task automatic predict_summary(logic [7:0] b, logic last);
    out_item_t s;
    logic [3:0] k;
    int unsigned start, stop;
    if (pm_pos < FRAME_CAP) begin
      parse_byte(b, pm_pos);
      pm_pos++;
    end
    if (!last) return;
    s = '0;
    k = pm_kind;
    s.packet_kind = k;
    if (k != KIND_UNKNOWN && k != KIND_DISCARD) begin
      s.ether_type = pm_cf[2][31:16];
      if (k == KIND_ARP) begin
        s.src_addr = pm_cf[0][63:32];
        s.dst_addr = pm_cf[0][31:0];
        s.ack_or_length = pm_cf[1][31:0];
      end else if (k >= KIND_IP4) begin
        s.proto_number = pm_nh;
        if (k <= KIND_IP4_FRAG) begin
          s.src_addr = pm_cf[0][63:32];
          s.dst_addr = pm_cf[0][31:0];
        end
        if (k inside {KIND_IP4_TCP, KIND_IP4_UDP, KIND_IP4_ICMP, KIND_IP6_TCP,
                      KIND_IP6_UDP}) begin
          s.src_port = pm_cf[2][63:48];
          s.dst_port = pm_cf[2][47:32];
        end
        if (k == KIND_IP4_TCP || k == KIND_IP6_TCP) begin
          s.seq_number = pm_cf[1][63:32];
          s.tcp_flag_bits = pm_cf[2][7:0];
        end
        if (k inside {KIND_IP4_TCP, KIND_IP4_UDP, KIND_IP6_TCP, KIND_IP6_UDP})
          s.ack_or_length = pm_cf[1][31:0];
        start = 32'(pm_cf[3][15:0]);
        stop = (pm_pos < pm_limit) ? pm_pos : pm_limit;
        s.payload_offset = start[11:0];
        s.payload_length = (stop > start) ? 12'(stop - start) : 12'd0;
      end
    end
    summary_q.push_back(s);
    frame_clear();
  endtask

  // ---------------- frame builders ----------------
  task automatic push_bytes(int n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push16(logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic eth_head(logic [15:0] et);
    frame_q.delete();
    push_bytes(12);
    push16(et);
  endtask

  // L4 header plus some payload; doff only matters for TCP.
  task automatic l4_part(logic [7:0] proto, logic [3:0] doff);
    if (proto == NH_TCP) begin
      push_bytes(12);
      frame_q.push_back({doff, 4'($urandom_range(0, 15))});
      push_bytes(7);
      if (doff > 5) push_bytes((doff - 5) * 4);
    end else if (proto == NH_UDP || proto == NH_ICMP) begin
      push_bytes(8);
    end
    push_bytes($urandom_range(0, 24));
  endtask

  task automatic build_arp(int cut);
    eth_head(ETYPE_ARP);
    push_bytes(28 + $urandom_range(0, 18));
    if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut-1];
  endtask

  task automatic build_ip4(logic [7:0] proto, logic [15:0] frag, logic [3:0] ihl,
                           logic [3:0] doff, int cut);
    eth_head(ETYPE_IP4);
    frame_q.push_back({4'd4, ihl});
    push_bytes(5);
    push16(frag);
    push_bytes(1);
    frame_q.push_back(proto);
    push_bytes(10);
    if (ihl > 5) push_bytes((ihl - 5) * 4);
    l4_part(proto, doff);
    if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut-1];
  endtask

  // IPv6 with the extension chain in chain_q and final next header last_nh.
  // plen_mode: 0 exact, 1 at most exact, 2 random, 3 larger.
  task automatic build_ip6(logic [3:0] ver, logic [7:0] last_nh, int plen_mode,
                           logic [3:0] doff, int cut);
    int plen_at, body;
    logic [7:0] nh_list[$];
    logic [15:0] plen;
    logic [7:0] r;
    eth_head(ETYPE_IP6);
    nh_list = chain_q;
    nh_list.push_back(last_nh);
    frame_q.push_back({ver, 4'($urandom_range(0, 15))});
    push_bytes(3);
    plen_at = frame_q.size();
    push16(16'd0);
    frame_q.push_back(nh_list[0]);
    push_bytes(33);
    for (int c = 0; c < chain_q.size(); c++) begin
      case (chain_q[c])
        NH_AH: begin
          r = 8'($urandom_range(1, 4));
          frame_q.push_back(nh_list[c+1]);
          frame_q.push_back(r);
          push_bytes((r + 2) * 4 - 2);
        end
        NH_FRAG: begin
          frame_q.push_back(nh_list[c+1]);
          push_bytes(1);
          if ($urandom_range(0, 2) == 0) push16(16'($urandom_range(0, 65535)));
          else push16(16'd0);
          push_bytes(4);
        end
        NH_ESP: push_bytes(8);
        default: begin
          r = 8'($urandom_range(0, 2));
          frame_q.push_back(nh_list[c+1]);
          frame_q.push_back(r);
          push_bytes((r + 1) * 8 - 2);
        end
      endcase
    end
    l4_part(last_nh, doff);
    body = frame_q.size() - 54;
    case (plen_mode)
      0: plen = 16'(body);
      1: plen = 16'($urandom_range(0, body));
      2: plen = 16'($urandom_range(0, 65535));
      default: plen = 16'(body + $urandom_range(1, 40));
    endcase
    frame_q[plen_at] = plen[15:8];
    frame_q[plen_at+1] = plen[7:0];
    if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut-1];
  endtask

  // ---------------- driving ----------------
  task automatic send_item(logic [7:0] b, logic last);
    int gap;
    if (idle_on && $urandom_range(0, 15) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_summary(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_item(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // Receiver stall: a long hold when asked, else random bursts.
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count > 0) begin
        out_stall <= 1'b1;
        hold_count--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (summary_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", out_item);
      end else begin
        want = summary_q.pop_front();
        kind_hits[want.packet_kind]++;
        if (out_item.packet_kind !== want.packet_kind ||
            out_item.ether_type !== want.ether_type ||
            out_item.proto_number !== want.proto_number ||
            out_item.src_addr !== want.src_addr ||
            out_item.dst_addr !== want.dst_addr ||
            out_item.src_port !== want.src_port ||
            out_item.dst_port !== want.dst_port ||
            out_item.seq_number !== want.seq_number ||
            out_item.ack_or_length !== want.ack_or_length ||
            out_item.tcp_flag_bits !== want.tcp_flag_bits ||
            out_item.payload_offset !== want.payload_offset ||
            out_item.payload_length !== want.payload_length) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_short_and_ethernet();
    frame_q.delete(); push_bytes(1); send_frame();
    frame_q.delete(); push_bytes(13); send_frame();
    eth_head(16'hFFFF); push_bytes(5); send_frame();
    eth_head(16'h0000); send_frame();
    build_arp(0); send_frame();
    build_arp(30); send_frame();
  endtask

  task automatic test_ipv4();
    build_ip4(NH_TCP, 16'h0000, 4'd5, 4'd5, 0); send_frame();
    build_ip4(NH_UDP, 16'h4000, 4'd5, 4'd5, 0); send_frame();
    build_ip4(NH_ICMP, 16'h4000, 4'd7, 4'd5, 0); send_frame();
    build_ip4(8'hFF, 16'h0000, 4'd15, 4'd5, 0); send_frame();
    build_ip4(NH_TCP, 16'h2000, 4'd5, 4'd5, 0); send_frame();
    build_ip4(NH_UDP, 16'h1FFF, 4'd5, 4'd5, 0); send_frame();
    build_ip4(NH_TCP, 16'h0000, 4'd4, 4'd5, 0); send_frame();
    build_ip4(NH_TCP, 16'h0000, 4'd5, 4'd4, 0); send_frame();
    build_ip4(NH_TCP, 16'h0000, 4'd5, 4'd15, 0); send_frame();
    build_ip4(NH_TCP, 16'h0000, 4'd5, 4'd5, 40); send_frame();
    build_ip4(NH_UDP, 16'h0000, 4'd5, 4'd5, 25); send_frame();
  endtask

  task automatic test_ipv6();
    chain_q.delete();
    build_ip6(4'd6, NH_TCP, 0, 4'd5, 0); send_frame();
    build_ip6(4'd6, NH_UDP, 3, 4'd5, 0); send_frame();
    build_ip6(4'd6, 8'd58, 0, 4'd5, 0); send_frame();
    build_ip6(4'd4, NH_TCP, 0, 4'd5, 0); send_frame();
    build_ip6(4'd6, NH_TCP, 0, 4'd5, 30); send_frame();
    build_ip6(4'd6, NH_TCP, 1, 4'd5, 0); send_frame();
    chain_q = '{NH_HOP, NH_ROUTE, NH_DEST, NH_AH};
    build_ip6(4'd6, NH_UDP, 0, 4'd5, 0); send_frame();
    chain_q = '{NH_FRAG};
    build_ip6(4'd6, NH_TCP, 0, 4'd5, 0); send_frame();
    chain_q = '{NH_ESP};
    build_ip6(4'd6, NH_TCP, 0, 4'd5, 0); send_frame();
    chain_q = '{NH_HOP};
    build_ip6(4'd6, NH_TCP, 1, 4'd5, 0); send_frame();
    chain_q.delete();
  endtask

  // Bytes past the frame cap are dropped but last_byte still closes it.
  task automatic test_long_frame();
    build_ip4(NH_UDP, 16'h0000, 4'd5, 4'd5, 0);
    push_bytes(FRAME_CAP + 60 - frame_q.size());
    send_frame();
  endtask

  // Hold the receiver for a long stretch while short frames keep coming.
  task automatic test_backpressure();
    hold_count = 400;
    repeat (24) begin
      frame_q.delete(); push_bytes($urandom_range(1, 3)); send_frame();
    end
  endtask

  task automatic random_frame();
    logic [7:0] pick_l4;
    int cut;
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 70) : 0;
    case ($urandom_range(0, 9))
      0: begin
        eth_head(16'($urandom_range(0, 65535))); push_bytes($urandom_range(0, 20));
        if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut-1];
      end
      1: build_arp(cut);
      2, 3, 4, 5: begin
        case ($urandom_range(0, 4))
          0: pick_l4 = NH_UDP;
          1: pick_l4 = NH_ICMP;
          2: pick_l4 = 8'($urandom_range(0, 255));
          default: pick_l4 = NH_TCP;
        endcase
        build_ip4(pick_l4,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 1) << 14),
                  ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(5, 7)),
                  ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(5, 7)),
                  cut);
      end
      default: begin
        chain_q.delete();
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 6))
            0: chain_q.push_back(NH_HOP);
            1: chain_q.push_back(NH_ROUTE);
            2: chain_q.push_back(NH_DEST);
            3: chain_q.push_back(NH_AH);
            4: chain_q.push_back(NH_FRAG);
            5: chain_q.push_back(NH_ESP);
            default: chain_q.push_back(NH_AH);
          endcase
        end
        case ($urandom_range(0, 4))
          0: pick_l4 = NH_UDP;
          1: pick_l4 = 8'd58;
          2: pick_l4 = 8'($urandom_range(0, 255));
          default: pick_l4 = NH_TCP;
        endcase
        build_ip6(($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd6,
                  pick_l4, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                  ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd5,
                  cut);
        chain_q.delete();
      end
    endcase
    send_frame();
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 800) begin
      // At every sixteenth frame, pick at random whether to idle.
      if (frames_sent % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
      random_frame();
    end
    idle_on = 1'b0;
    repeat (6) random_frame();
  endtask

  initial begin
    errors = 0; frames_sent = 0; bytes_sent = 0; results_seen = 0;
    hold_count = 0; idle_on = 1'b0;
    foreach (kind_hits[k]) kind_hits[k] = 0;
    frame_clear();
    in_valid = 1'b0;
    in_item = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    test_short_and_ethernet();
    test_ipv4();
    test_ipv6();
    test_long_frame();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d frames, %0d bytes, %0d results; kinds eth %0d arp %0d ip4 %0d",
             frames_sent, bytes_sent, results_seen, kind_hits[KIND_ETH],
             kind_hits[KIND_ARP], kind_hits[KIND_IP4] + kind_hits[KIND_IP4_TCP] +
             kind_hits[KIND_IP4_UDP] + kind_hits[KIND_IP4_ICMP] + kind_hits[KIND_IP4_FRAG]);
    $display("ip6 %0d (tcp %0d udp %0d) discarded %0d unknown %0d, mismatches %0d",
             kind_hits[KIND_IP6], kind_hits[KIND_IP6_TCP], kind_hits[KIND_IP6_UDP],
             kind_hits[KIND_DISCARD], kind_hits[KIND_UNKNOWN], errors);
    if (errors == 0) begin
      $display("tb_ethernet_ip_l4_header_parser_top: clean");
    end else begin
      $display("tb_ethernet_ip_l4_header_parser_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
